// ===== rtl/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants for the 1-Wire bus master: command codes,
// sequencer phases, timing register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

    // Widths fixed by the item format
    localparam int CMD_W      = 3;
    localparam int BYTE_BITS  = 8;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int BIT_CNT_W  = $clog2(BYTE_BITS);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESET  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WBIT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RBIT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WBYTE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RBYTE  = 3'd5;

    // Timing register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DLY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LEN   = 3'd6;

    // Standard timing values in microseconds
    localparam logic [CFG_W-1:0] RST_RESET_LOW  = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRES_WAIT  = 10'd70;
    localparam logic [CFG_W-1:0] RST_RESET_TAIL = 10'd410;
    localparam logic [CFG_W-1:0] RST_SHORT_LOW  = 10'd6;
    localparam logic [CFG_W-1:0] RST_LONG_LOW   = 10'd60;
    localparam logic [CFG_W-1:0] RST_SAMPLE_DLY = 10'd9;
    localparam logic [CFG_W-1:0] RST_SLOT_LEN   = 10'd70;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RLOW  = 3'd1,
        PH_RWAIT = 3'd2,
        PH_RTAIL = 3'd3,
        PH_SLOW  = 3'd4,
        PH_SREL  = 3'd5
    } phase_t;

    // Timing register file
    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_wait;
        logic [CFG_W-1:0] reset_tail;
        logic [CFG_W-1:0] short_low_time;
        logic [CFG_W-1:0] long_low_time;
        logic [CFG_W-1:0] sample_delay;
        logic [CFG_W-1:0] slot_length;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic                 drive_low;
        logic                 busy_res;
        logic                 done_res;
        logic                 presence;
        logic [BYTE_BITS-1:0] read_data;
        logic                 rejected;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/owm_core.sv =====
// ----------------------------------------------------------------------------
// owm_core
// Bus sequencer: phase, microsecond timer, bit counter and shift register,
// advanced by one item per enabled cycle, with the result of that item.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_core #(
    parameter int TIMER_WIDTH = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step_en,
    input  wire logic [owm_pkg::CMD_W-1:0]     cmd,
    input  wire logic [owm_pkg::BYTE_BITS-1:0] write_data,
    input  wire logic                          line_level,
    input  wire owm_pkg::cfg_t                 cfg,
    output owm_pkg::res_t                      res
);

    localparam int CW = (TIMER_WIDTH > owm_pkg::CFG_W) ? TIMER_WIDTH : owm_pkg::CFG_W;
    localparam logic [CW-1:0]          TMAX_C = CW'({TIMER_WIDTH{1'b1}});
    localparam logic [TIMER_WIDTH-1:0] TMAX_T = {TIMER_WIDTH{1'b1}};
    localparam logic [TIMER_WIDTH-1:0] ONE_T  = TIMER_WIDTH'(1);
    localparam logic [owm_pkg::BIT_CNT_W-1:0] LAST_BIT =
        owm_pkg::BIT_CNT_W'(owm_pkg::BYTE_BITS - 1);

    // Timing value: zero acts as one, clipped to the timer range
    function automatic logic [TIMER_WIDTH-1:0] span(input logic [owm_pkg::CFG_W-1:0] v);
        logic [CW-1:0] x;
        x = CW'(v);
        if (x == '0)
        begin
            x = CW'(1);
        end
        if (x > TMAX_C)
        begin
            x = TMAX_C;
        end
        return x[TIMER_WIDTH-1:0];
    endfunction

    owm_pkg::phase_t                 phase_reg, phase_next;
    logic [owm_pkg::CMD_W-1:0]       op_reg, op_next;
    logic [TIMER_WIDTH-1:0]          timer_reg, timer_next;
    logic [owm_pkg::BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [owm_pkg::BYTE_BITS-1:0]   shift_reg, shift_next;
    logic                            presence_reg, presence_next;

    logic                            is_read;
    logic                            is_byte;
    logic [TIMER_WIDTH-1:0]          timer_inc;
    logic [TIMER_WIDTH-1:0]          low_t;
    logic [TIMER_WIDTH-1:0]          slot_t;
    logic [TIMER_WIDTH-1:0]          samp_t;
    logic [TIMER_WIDTH-1:0]          rel_base;
    logic [TIMER_WIDTH-1:0]          rel_t;
    logic                            sample_hit;
    logic [owm_pkg::BYTE_BITS-1:0]   shift_sampled;
    logic                            is_cmd;
    logic                            done_flag;
    logic                            rej_flag;
    logic [owm_pkg::BYTE_BITS-1:0]   rd_byte;

    // Slot timing derived from the current operation
    assign is_read = (op_reg == owm_pkg::CMD_RBIT) || (op_reg == owm_pkg::CMD_RBYTE);
    assign is_byte = (op_reg == owm_pkg::CMD_WBYTE) || (op_reg == owm_pkg::CMD_RBYTE);
    assign timer_inc = (timer_reg == TMAX_T) ? timer_reg : timer_reg + ONE_T;
    assign low_t  = span((is_read || shift_reg[0]) ? cfg.short_low_time : cfg.long_low_time);
    assign slot_t = span(cfg.slot_length);
    assign samp_t = span(cfg.sample_delay);
    assign rel_base = (slot_t > low_t) ? slot_t - low_t : ONE_T;
    assign rel_t = (is_read && (samp_t > rel_base)) ? samp_t : rel_base;

    // Read sample lands in the shift register, LSB first
    assign sample_hit = is_read && (timer_inc == samp_t);
    assign shift_sampled = !sample_hit ? shift_reg
                         : (op_reg == owm_pkg::CMD_RBIT)
                           ? {{(owm_pkg::BYTE_BITS-1){1'b0}}, line_level}
                           : {line_level, shift_reg[owm_pkg::BYTE_BITS-1:1]};

    assign is_cmd = (cmd == owm_pkg::CMD_RESET) || (cmd == owm_pkg::CMD_WBIT)
                 || (cmd == owm_pkg::CMD_RBIT)  || (cmd == owm_pkg::CMD_WBYTE)
                 || (cmd == owm_pkg::CMD_RBYTE);

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        op_next       = op_reg;
        timer_next    = timer_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        done_flag     = 1'b0;
        rej_flag      = 1'b0;
        rd_byte       = '0;
        if (is_cmd)
        begin
            if (phase_reg != owm_pkg::PH_IDLE)
            begin
                rej_flag = 1'b1;
            end
            else
            begin
                op_next      = cmd;
                timer_next   = '0;
                bit_cnt_next = '0;
                if (cmd == owm_pkg::CMD_RESET)
                begin
                    phase_next = owm_pkg::PH_RLOW;
                end
                else
                begin
                    phase_next = owm_pkg::PH_SLOW;
                    if (cmd == owm_pkg::CMD_WBIT)
                    begin
                        shift_next = {{(owm_pkg::BYTE_BITS-1){1'b0}}, write_data[0]};
                    end
                    else if (cmd == owm_pkg::CMD_WBYTE)
                    begin
                        shift_next = write_data;
                    end
                    else
                    begin
                        shift_next = '0;
                    end
                end
            end
        end
        else if ((cmd == owm_pkg::CMD_TICK) && (phase_reg != owm_pkg::PH_IDLE))
        begin
            timer_next = timer_inc;
            unique case (phase_reg)
                owm_pkg::PH_RLOW:
                begin
                    if (timer_inc >= span(cfg.reset_low_time))
                    begin
                        phase_next = owm_pkg::PH_RWAIT;
                        timer_next = '0;
                    end
                end
                owm_pkg::PH_RWAIT:
                begin
                    if (timer_inc >= span(cfg.presence_wait))
                    begin
                        presence_next = ~line_level;
                        phase_next    = owm_pkg::PH_RTAIL;
                        timer_next    = '0;
                    end
                end
                owm_pkg::PH_RTAIL:
                begin
                    if (timer_inc >= span(cfg.reset_tail))
                    begin
                        phase_next = owm_pkg::PH_IDLE;
                        timer_next = '0;
                        done_flag  = 1'b1;
                    end
                end
                owm_pkg::PH_SLOW:
                begin
                    if (timer_inc >= low_t)
                    begin
                        phase_next = owm_pkg::PH_SREL;
                        timer_next = '0;
                    end
                end
                owm_pkg::PH_SREL:
                begin
                    shift_next = shift_sampled;
                    if (timer_inc >= rel_t)
                    begin
                        timer_next = '0;
                        if (op_reg == owm_pkg::CMD_WBYTE)
                        begin
                            shift_next = shift_sampled >> 1;
                        end
                        if (is_byte && (bit_cnt_reg != LAST_BIT))
                        begin
                            bit_cnt_next = bit_cnt_reg + 1'b1;
                            phase_next   = owm_pkg::PH_SLOW;
                        end
                        else
                        begin
                            phase_next = owm_pkg::PH_IDLE;
                            done_flag  = 1'b1;
                            if (is_read)
                            begin
                                rd_byte = shift_sampled;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result item
    always_comb
    begin
        res.drive_low = (phase_next == owm_pkg::PH_RLOW) || (phase_next == owm_pkg::PH_SLOW);
        res.busy_res  = (phase_next != owm_pkg::PH_IDLE);
        res.done_res  = done_flag;
        res.presence  = presence_next;
        res.read_data = rd_byte;
        res.rejected  = rej_flag;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= owm_pkg::PH_IDLE;
            op_reg       <= '0;
            timer_reg    <= '0;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            op_reg       <= op_next;
            timer_reg    <= timer_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/onewire_bus_master_top.sv =====
// ----------------------------------------------------------------------------
// onewire_bus_master_top
// 1-Wire bus master. Each input item is a one-microsecond tick with the
// sampled bus level, or a reset / bit / byte command.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): cmd, write_data, line_level. Send one
//    tick item per microsecond; commands go in between ticks.
//  - Output channel (out_valid/out_ready): one result item per input item,
//    in order. drive_low applies to the microsecond after that item.
//  - Config channel (cfg_valid/cfg_ready): cfg_index selects a timing
//    register, cfg_data is written. Always ready. Write only while idle.
//  - Path: an accepted item is registered in the input stage, then stepped
//    through the sequencer into the output register and offered from there.
//  - Throughput: one item per cycle while the output is not stalled; the
//    sequencer state update is combinational, so items flow back to back.
//  - Reset: sequencer idle, timing registers at standard values, presence
//    cleared, both pipeline stages empty.
//  - Output stall: the output register holds; the input stage holds one
//    more item, after which in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_bus_master_top #(
    parameter int TIMER_WIDTH = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // item input
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [owm_pkg::CMD_W-1:0]         cmd,
    input  wire logic [owm_pkg::BYTE_BITS-1:0]     write_data,
    input  wire logic                              line_level,
    // result output
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   drive_low,
    output logic                                   busy_res,
    output logic                                   done_res,
    output logic                                   presence,
    output logic [owm_pkg::BYTE_BITS-1:0]          read_data,
    output logic                                   rejected,
    // timing registers
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [owm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [owm_pkg::CFG_W-1:0]         cfg_data
);

    owm_pkg::cfg_t                   cfg_reg;
    logic                            s1_valid_reg;
    logic [owm_pkg::CMD_W-1:0]       s1_cmd_reg;
    logic [owm_pkg::BYTE_BITS-1:0]   s1_wd_reg;
    logic                            s1_lvl_reg;
    logic                            out_valid_reg;
    owm_pkg::res_t                   out_res_reg;
    owm_pkg::res_t                   step_res;
    logic                            advance;

    // Pipeline handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Timing register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time <= owm_pkg::RST_RESET_LOW;
            cfg_reg.presence_wait  <= owm_pkg::RST_PRES_WAIT;
            cfg_reg.reset_tail     <= owm_pkg::RST_RESET_TAIL;
            cfg_reg.short_low_time <= owm_pkg::RST_SHORT_LOW;
            cfg_reg.long_low_time  <= owm_pkg::RST_LONG_LOW;
            cfg_reg.sample_delay   <= owm_pkg::RST_SAMPLE_DLY;
            cfg_reg.slot_length    <= owm_pkg::RST_SLOT_LEN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                owm_pkg::CFG_RESET_LOW:  cfg_reg.reset_low_time <= cfg_data;
                owm_pkg::CFG_PRES_WAIT:  cfg_reg.presence_wait  <= cfg_data;
                owm_pkg::CFG_RESET_TAIL: cfg_reg.reset_tail     <= cfg_data;
                owm_pkg::CFG_SHORT_LOW:  cfg_reg.short_low_time <= cfg_data;
                owm_pkg::CFG_LONG_LOW:   cfg_reg.long_low_time  <= cfg_data;
                owm_pkg::CFG_SAMPLE_DLY: cfg_reg.sample_delay   <= cfg_data;
                owm_pkg::CFG_SLOT_LEN:   cfg_reg.slot_length    <= cfg_data;
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg <= cmd;
            s1_wd_reg  <= write_data;
            s1_lvl_reg <= line_level;
        end
    end

    // Sequencer
    owm_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .cmd        (s1_cmd_reg),
        .write_data (s1_wd_reg),
        .line_level (s1_lvl_reg),
        .cfg        (cfg_reg),
        .res        (step_res)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign drive_low  = out_res_reg.drive_low;
    assign busy_res   = out_res_reg.busy_res;
    assign done_res   = out_res_reg.done_res;
    assign presence   = out_res_reg.presence;
    assign read_data  = out_res_reg.read_data;
    assign rejected   = out_res_reg.rejected;

    // A rejected command leaves the sequencer busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.rejected) |-> out_res_reg.busy_res)
        else $error("rejected command while sequencer idle");

    // Completion coincides with return to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.done_res) |-> !out_res_reg.busy_res)
        else $error("done reported while still busy");

    // Bus is driven only during an operation
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.drive_low) |-> out_res_reg.busy_res)
        else $error("bus driven low while idle");

    // Read data appears only on a completion
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.read_data != '0)) |-> out_res_reg.done_res)
        else $error("read data outside a done item");

endmodule

`default_nettype wire

// ===== tb/onewire_bus_master_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_bus_master_top_test
// Self-checking bench for the 1-Wire bus master. Drives tick and command
// items, keeps its own item-by-item model of the slot sequencer and checks
// every result item in order. Walks through several timing settings
// (standard, compact, zero, small, wider spread) under different idle and
// stall patterns.
// ----------------------------------------------------------------------------

module onewire_bus_master_top_test;

    localparam int TIMER_W        = 10;
    localparam int TMAX           = (1 << TIMER_W) - 1;
    localparam int N_TIMING       = 7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 70;

    // Command codes the block ignores
    localparam logic [owm_pkg::CMD_W-1:0] CMD_FIRST_UNDEF =
        owm_pkg::CMD_W'(owm_pkg::CMD_RBYTE + 1);
    localparam logic [owm_pkg::CMD_W-1:0] CMD_LAST        = '1;
    // Register index with no register behind it
    localparam logic [owm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = '1;

    // Bus level policy for tick items
    localparam int LVL_LOW    = 0;
    localparam int LVL_HIGH   = 1;
    localparam int LVL_RANDOM = 2;

    // ------------------------------------------------------------------------
    // Scoreboard: slot sequencer model plus queue of results still due
    // ------------------------------------------------------------------------
    class slot_scoreboard;
        logic [owm_pkg::CFG_W-1:0] timing [N_TIMING];
        owm_pkg::phase_t           phase;
        logic [owm_pkg::CMD_W-1:0] op;
        int                        timer;
        int                        bit_cnt;
        logic [7:0]                shreg;
        logic                      pres;
        owm_pkg::res_t             bus_results_due [$];
        int                        failures;

        function new();
            timing[owm_pkg::CFG_RESET_LOW]  = owm_pkg::RST_RESET_LOW;
            timing[owm_pkg::CFG_PRES_WAIT]  = owm_pkg::RST_PRES_WAIT;
            timing[owm_pkg::CFG_RESET_TAIL] = owm_pkg::RST_RESET_TAIL;
            timing[owm_pkg::CFG_SHORT_LOW]  = owm_pkg::RST_SHORT_LOW;
            timing[owm_pkg::CFG_LONG_LOW]   = owm_pkg::RST_LONG_LOW;
            timing[owm_pkg::CFG_SAMPLE_DLY] = owm_pkg::RST_SAMPLE_DLY;
            timing[owm_pkg::CFG_SLOT_LEN]   = owm_pkg::RST_SLOT_LEN;
            phase    = owm_pkg::PH_IDLE;
            op       = owm_pkg::CMD_TICK;
            timer    = 0;
            bit_cnt  = 0;
            shreg    = '0;
            pres     = 1'b0;
            failures = 0;
        endfunction

        function void set_timing(logic [owm_pkg::CFG_IDX_W-1:0] idx,
                                 logic [owm_pkg::CFG_W-1:0] data);
            if (idx < N_TIMING)
            begin
                timing[idx] = data;
            end
        endfunction

        function bit sequencer_idle();
            return phase == owm_pkg::PH_IDLE;
        endfunction

        // zero acts as one microsecond, clipped to the timer range
        function int span(int v);
            if (v == 0)
            begin
                v = 1;
            end
            return (v > TMAX) ? TMAX : v;
        endfunction

        function bit is_read();
            return op == owm_pkg::CMD_RBIT || op == owm_pkg::CMD_RBYTE;
        endfunction

        function int low_time();
            if (is_read())
            begin
                return span(int'(timing[owm_pkg::CFG_SHORT_LOW]));
            end
            return span(int'(shreg[0] ? timing[owm_pkg::CFG_SHORT_LOW]
                                      : timing[owm_pkg::CFG_LONG_LOW]));
        endfunction

        // Step the sequencer by one accepted item and queue the result
        function void advance_bus_sequencer(logic [owm_pkg::CMD_W-1:0] c, logic [7:0] wd,
                                            logic lvl);
            owm_pkg::res_t r;
            int            lt;
            int            sl;
            int            rel;
            int            sd;
            r = '0;
            if (c >= owm_pkg::CMD_RESET && c <= owm_pkg::CMD_RBYTE)
            begin
                if (phase != owm_pkg::PH_IDLE)
                begin
                    r.rejected = 1'b1;
                end
                else
                begin
                    op      = c;
                    timer   = 0;
                    bit_cnt = 0;
                    if (c == owm_pkg::CMD_RESET)
                    begin
                        phase = owm_pkg::PH_RLOW;
                    end
                    else
                    begin
                        if (c == owm_pkg::CMD_WBIT)
                            shreg = {7'd0, wd[0]};
                        else if (c == owm_pkg::CMD_WBYTE)
                            shreg = wd;
                        else
                            shreg = '0;
                        phase = owm_pkg::PH_SLOW;
                    end
                end
            end
            else if (c == owm_pkg::CMD_TICK && phase != owm_pkg::PH_IDLE)
            begin
                if (timer < TMAX)
                begin
                    timer++;
                end
                case (phase)
                    owm_pkg::PH_RLOW:
                    begin
                        if (timer >= span(int'(timing[owm_pkg::CFG_RESET_LOW])))
                        begin
                            phase = owm_pkg::PH_RWAIT;
                            timer = 0;
                        end
                    end
                    owm_pkg::PH_RWAIT:
                    begin
                        // presence pulse is active low
                        if (timer >= span(int'(timing[owm_pkg::CFG_PRES_WAIT])))
                        begin
                            pres  = ~lvl;
                            phase = owm_pkg::PH_RTAIL;
                            timer = 0;
                        end
                    end
                    owm_pkg::PH_RTAIL:
                    begin
                        if (timer >= span(int'(timing[owm_pkg::CFG_RESET_TAIL])))
                        begin
                            phase      = owm_pkg::PH_IDLE;
                            timer      = 0;
                            r.done_res = 1'b1;
                        end
                    end
                    owm_pkg::PH_SLOW:
                    begin
                        if (timer >= low_time())
                        begin
                            phase = owm_pkg::PH_SREL;
                            timer = 0;
                        end
                    end
                    default:
                    begin
                        // release part of the slot, at least one microsecond
                        lt  = low_time();
                        sl  = span(int'(timing[owm_pkg::CFG_SLOT_LEN]));
                        rel = (sl > lt) ? sl - lt : 1;
                        sd  = span(int'(timing[owm_pkg::CFG_SAMPLE_DLY]));
                        if (is_read())
                        begin
                            if (timer == sd)
                            begin
                                if (op == owm_pkg::CMD_RBIT)
                                    shreg = {7'd0, lvl};
                                else
                                    shreg = {lvl, shreg[7:1]};
                            end
                            if (sd > rel)
                            begin
                                rel = sd;
                            end
                        end
                        if (timer >= rel)
                        begin
                            timer = 0;
                            if ((op == owm_pkg::CMD_WBYTE || op == owm_pkg::CMD_RBYTE) &&
                                bit_cnt < owm_pkg::BYTE_BITS - 1)
                            begin
                                bit_cnt++;
                                if (op == owm_pkg::CMD_WBYTE)
                                    shreg = shreg >> 1;
                                phase = owm_pkg::PH_SLOW;
                            end
                            else
                            begin
                                phase      = owm_pkg::PH_IDLE;
                                r.done_res = 1'b1;
                                if (is_read())
                                    r.read_data = shreg;
                                if (op == owm_pkg::CMD_WBYTE)
                                    shreg = shreg >> 1;
                            end
                        end
                    end
                endcase
            end
            r.drive_low = (phase == owm_pkg::PH_RLOW || phase == owm_pkg::PH_SLOW);
            r.busy_res  = (phase != owm_pkg::PH_IDLE);
            r.presence  = pres;
            bus_results_due.push_back(r);
        endfunction

        // Compare one result item against the oldest one due
        function void check_result(owm_pkg::res_t got);
            owm_pkg::res_t want;
            if (bus_results_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] result item with none due: %h", $realtime, got);
                return;
            end
            want = bus_results_due.pop_front();
            if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res || got.presence !== want.presence ||
                got.read_data !== want.read_data || got.rejected !== want.rejected)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $write("[%0t] mismatch dl/busy/done/pres/rd/rej want %b %b %b %b %02h %b",
                           $realtime, want.drive_low, want.busy_res, want.done_res,
                           want.presence, want.read_data, want.rejected);
                    $display(" got %b %b %b %b %02h %b",
                             got.drive_low, got.busy_res, got.done_res,
                             got.presence, got.read_data, got.rejected);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and instance
    // ------------------------------------------------------------------------
    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [owm_pkg::CMD_W-1:0]     cmd;
    logic [owm_pkg::BYTE_BITS-1:0] write_data;
    logic                          line_level;
    logic                          out_valid;
    logic                          out_ready;
    logic                          drive_low;
    logic                          busy_res;
    logic                          done_res;
    logic                          presence;
    logic [owm_pkg::BYTE_BITS-1:0] read_data;
    logic                          rejected;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [owm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [owm_pkg::CFG_W-1:0]     cfg_data;

    owm_pkg::res_t                 dut_result;
    slot_scoreboard                board = new();
    logic [owm_pkg::CFG_W-1:0]     timing_plan [N_TIMING];
    int                            sender_gap_pct;
    int                            ready_stall_pct;
    bit                            hold_request;
    int                            hold_left;
    int                            stalled_cycles;

    onewire_bus_master_top #(
        .TIMER_WIDTH (TIMER_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .write_data (write_data),
        .line_level (line_level),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive_low  (drive_low),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .presence   (presence),
        .read_data  (read_data),
        .rejected   (rejected),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    assign dut_result = {drive_low, busy_res, done_res, presence, read_data, rejected};

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor: model update on input items, check on result items
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_timing(cfg_index, cfg_data);
            if (in_valid && in_ready)
                board.advance_bus_sequencer(cmd, write_data, line_level);
            if (out_valid && out_ready)
                board.check_result(dut_result);
        end
    end

    // Watchdog on cycles with no handshake at all
    initial
    begin
        stalled_cycles = 0;
        while (stalled_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
                out_ready    = 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
            begin
                out_ready = ($urandom_range(0, 99) >= ready_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks; each starts and ends just after a falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [owm_pkg::CMD_W-1:0] c, input logic [7:0] wd,
                             input logic lvl);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        cmd        = c;
        write_data = wd;
        line_level = lvl;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic level_for(input int mode);
        if (mode == LVL_LOW)
            return 1'b0;
        if (mode == LVL_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // Ticks until the sequencer is back in idle
    task automatic finish_command(input int mode);
        while (!board.sequencer_idle())
        begin
            send_item(owm_pkg::CMD_TICK, 8'($urandom_range(0, 255)), level_for(mode));
        end
    endtask

    // One command, optionally poked by a second one while busy, then its ticks
    task automatic run_command(input logic [owm_pkg::CMD_W-1:0] c, input logic [7:0] wd,
                               input int mode, input bit poke);
        send_item(c, wd, level_for(mode));
        if (poke)
        begin
            send_item(owm_pkg::CMD_W'($urandom_range(owm_pkg::CMD_RESET, owm_pkg::CMD_RBYTE)),
                      8'($urandom_range(0, 255)), 1'b0);
        end
        finish_command(mode);
    endtask

    // Random traffic: mostly complete commands, some noise and busy pokes
    task automatic random_traffic(input int n);
        int                        counted;
        int                        r;
        logic [owm_pkg::CMD_W-1:0] c;
        counted = 0;
        while (counted < n)
        begin
            r = $urandom_range(0, 99);
            if (board.sequencer_idle())
            begin
                if (r < 8)
                    c = owm_pkg::CMD_TICK;
                else if (r < 12)
                    c = owm_pkg::CMD_W'($urandom_range(CMD_FIRST_UNDEF, CMD_LAST));
                else
                    c = owm_pkg::CMD_W'($urandom_range(owm_pkg::CMD_RESET,
                                                       owm_pkg::CMD_RBYTE));
            end
            else
            begin
                if (r < 4)
                    c = owm_pkg::CMD_W'($urandom_range(owm_pkg::CMD_RESET, CMD_LAST));
                else
                    c = owm_pkg::CMD_TICK;
            end
            if (!(board.sequencer_idle() &&
                  (c == owm_pkg::CMD_TICK || c > owm_pkg::CMD_RBYTE)))
                counted++;
            send_item(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        finish_command(LVL_RANDOM);
    endtask

    // Hold the input until every result is back, then idle a while longer
    task automatic settle();
        in_valid = 1'b0;
        while (board.bus_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [owm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [owm_pkg::CFG_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_timing();
        for (int i = 0; i < N_TIMING; i++)
        begin
            write_reg(owm_pkg::CFG_IDX_W'(i), timing_plan[i]);
        end
        cfg_valid = 1'b0;
    endtask

    task automatic plan_uniform(input int lo, input int hi);
        for (int i = 0; i < N_TIMING; i++)
        begin
            timing_plan[i] = owm_pkg::CFG_W'($urandom_range(lo, hi));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        cmd             = owm_pkg::CMD_TICK;
        write_data      = '0;
        line_level      = 1'b1;
        cfg_valid       = 1'b0;
        cfg_index       = owm_pkg::CFG_RESET_LOW;
        cfg_data        = '0;
        sender_gap_pct  = 0;
        ready_stall_pct = 0;
        hold_request    = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Standard timing out of reset: one write-zero slot, one read slot
        send_item(owm_pkg::CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_FIRST_UNDEF, 8'hFF, 1'b1);
        send_item(CMD_LAST, 8'h00, 1'b0);
        run_command(owm_pkg::CMD_WBIT, 8'hFE, LVL_RANDOM, 1'b1);
        run_command(owm_pkg::CMD_RBIT, 8'hFF, LVL_LOW, 1'b0);
        settle();

        // Compact timing for the directed part
        timing_plan[owm_pkg::CFG_RESET_LOW]  = 10'd4;
        timing_plan[owm_pkg::CFG_PRES_WAIT]  = 10'd2;
        timing_plan[owm_pkg::CFG_RESET_TAIL] = 10'd3;
        timing_plan[owm_pkg::CFG_SHORT_LOW]  = 10'd1;
        timing_plan[owm_pkg::CFG_LONG_LOW]   = 10'd3;
        timing_plan[owm_pkg::CFG_SAMPLE_DLY] = 10'd2;
        timing_plan[owm_pkg::CFG_SLOT_LEN]   = 10'd4;
        apply_timing();

        // Directed: resets with and without presence, both write bit values,
        // reads, byte extremes, busy pokes
        run_command(owm_pkg::CMD_RESET, 8'h00, LVL_LOW, 1'b1);
        run_command(owm_pkg::CMD_RESET, 8'hFF, LVL_HIGH, 1'b0);
        run_command(owm_pkg::CMD_WBIT, 8'hFE, LVL_RANDOM, 1'b1);
        run_command(owm_pkg::CMD_WBIT, 8'h01, LVL_RANDOM, 1'b0);
        run_command(owm_pkg::CMD_RBIT, 8'h00, LVL_HIGH, 1'b0);
        run_command(owm_pkg::CMD_RBIT, 8'hFF, LVL_LOW, 1'b1);
        run_command(owm_pkg::CMD_WBYTE, 8'hFF, LVL_RANDOM, 1'b1);
        run_command(owm_pkg::CMD_WBYTE, 8'hA5, LVL_RANDOM, 1'b0);
        run_command(owm_pkg::CMD_RBYTE, 8'h00, LVL_HIGH, 1'b0);
        run_command(owm_pkg::CMD_RBYTE, 8'h00, LVL_LOW, 1'b1);
        settle();

        // Small timings, no idling, one long output hold-off
        plan_uniform(0, 12);
        apply_timing();
        write_reg(CFG_UNUSED_IDX, owm_pkg::CFG_W'($urandom_range(0, 1023)));
        cfg_valid    = 1'b0;
        hold_request = 1'b1;
        random_traffic(PHASE_ITEMS);
        settle();

        // Every register zero, sender mostly idle
        plan_uniform(0, 0);
        apply_timing();
        sender_gap_pct = 80;
        random_traffic(PHASE_ITEMS);
        settle();

        // Small timings, receiver mostly stalled
        plan_uniform(1, 12);
        apply_timing();
        sender_gap_pct  = 0;
        ready_stall_pct = 80;
        random_traffic(PHASE_ITEMS);
        settle();

        // Wider spread, slots often shorter than their low time, both idle
        plan_uniform(0, 24);
        apply_timing();
        sender_gap_pct  = 21;
        ready_stall_pct = 21;
        random_traffic(PHASE_ITEMS);
        settle();

        repeat (10) @(posedge clk);
        if (board.failures == 0 && board.bus_results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== onewire_bus_master_top.f =====
rtl/owm_pkg.sv
rtl/owm_core.sv
rtl/onewire_bus_master_top.sv
tb/onewire_bus_master_top_test.sv
